// ===== rtl/core/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD_HDL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_SPLIT,
    S_FRD,
    S_FCHK,
    S_SHIFT,
    S_OUT
  } state_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
endpackage

// ===== rtl/core/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall, in_action, in_req_size, in_handle
// out     | output    | out_valid, out_stall, out_status, out_block_handle,
//         |           | out_payload_start, out_payload_end, out_free_bytes
// A transaction is accepted; then each table entry visited is read, then checked;
// each entry moved by a split or a merge is read, then written, and each split or
// removal ends with a closing step; finally the result is presented.
// The longest transaction is a free that merges on both sides.
// rst_n is synchronous, active low; it restores one free block spanning the buffer.
// The input is stalled from the accept until the result is taken; a stalled result holds.
module first_fit_block_allocator #(
  parameter int BUF_BYTES    = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [12:0] in_req_size,
  input  logic [11:0] in_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_block_handle,
  output logic [12:0] out_payload_start,
  output logic [12:0] out_payload_end,
  output logic [12:0] out_free_bytes
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(BUF_BYTES + 1) + 1;
  localparam logic [AW-1:0] BUF_A = AW'(BUF_BYTES);
  localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);

  // block table: start offsets and used marks, kept in address order
  logic [AW-1:0] start_r [MAX_BLOCKS];
  logic          used_r  [MAX_BLOCKS];
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] free_r;

  ffba_pkg::state_t  st_r, st_nxt;
  logic [IW-1:0]     i_r;
  logic              act_r;
  logic [AW-1:0]     size_r;
  logic [11:0]       hdl_r;
  ffba_pkg::status_t stat_r;
  logic [AW-1:0]     bh_r;
  logic              prev_used_r;  // used mark of entry i-1 during a free scan
  // table move bookkeeping
  logic [IW-1:0] j_r;
  logic          ph_r;      // 0 reads the entry to move, 1 writes it
  logic          rem_r;     // a second removal is pending
  logic [IW-1:0] rm2_r;
  // registered table reads: port a at ra, port b at rb
  logic [IW-1:0] ra, rb;
  logic [AW-1:0] qa_start_r, qb_start_r;
  logic          qa_used_r, qb_used_r;
  // table write port
  logic          we;
  logic [IW-1:0] wa;
  logic [AW-1:0] wd_start;
  logic          wd_used;
  logic [AW-1:0] end_s, span, pay;
  logic          last, fit, do_split, hit, mrg_hi, mrg_lo;
  logic          split_done, shift_end, alloc_ok;

  // shared datapath: end and payload of entry i from the registered reads
  assign last       = (CW'(i_r) + 1'b1) >= cnt_r;
  assign end_s      = last ? BUF_A : qb_start_r;
  assign span       = end_s - qa_start_r;
  assign pay        = (span >= HDR_A) ? span - HDR_A : '0;
  assign fit        = !qa_used_r && (pay >= size_r);
  assign do_split   = ((pay - size_r) > HDR_A) && (cnt_r < CW'(MAX_BLOCKS));
  assign hit        = (qa_start_r == AW'(hdl_r));
  assign mrg_hi     = !last && !qb_used_r;
  assign mrg_lo     = (i_r != '0) && !prev_used_r;
  assign split_done = (j_r == IW'(i_r + 1'b1));
  assign shift_end  = (CW'(j_r) + 1'b1) >= cnt_r;
  assign alloc_ok   = (act_r == ffba_pkg::ACT_ALLOC) && (stat_r == ffba_pkg::ST_DONE);

  assign out_status        = stat_r;
  assign out_block_handle  = bh_r[11:0];
  assign out_payload_start = alloc_ok ? 13'(bh_r + HDR_A) : '0;
  assign out_payload_end   = alloc_ok ? 13'(bh_r + HDR_A + size_r) : '0;
  assign out_free_bytes    = free_r[12:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ffba_pkg::S_IDLE: begin
        if (in_valid)
          st_nxt = (in_action == ffba_pkg::ACT_ALLOC) ? ffba_pkg::S_ARD : ffba_pkg::S_FRD;
      end
      ffba_pkg::S_ARD: st_nxt = ffba_pkg::S_ACHK;
      ffba_pkg::S_ACHK: begin
        if (fit) st_nxt = do_split ? ffba_pkg::S_SPLIT : ffba_pkg::S_OUT;
        else st_nxt = last ? ffba_pkg::S_OUT : ffba_pkg::S_ARD;
      end
      ffba_pkg::S_SPLIT: if (!ph_r && split_done) st_nxt = ffba_pkg::S_OUT;
      ffba_pkg::S_FRD: st_nxt = ffba_pkg::S_FCHK;
      ffba_pkg::S_FCHK: begin
        if (hit)
          st_nxt = (qa_used_r && (mrg_hi || mrg_lo)) ? ffba_pkg::S_SHIFT : ffba_pkg::S_OUT;
        else
          st_nxt = last ? ffba_pkg::S_OUT : ffba_pkg::S_FRD;
      end
      ffba_pkg::S_SHIFT: if (!ph_r && shift_end && !rem_r) st_nxt = ffba_pkg::S_OUT;
      ffba_pkg::S_OUT: if (!out_stall) st_nxt = ffba_pkg::S_IDLE;
      default: st_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // handshake outputs and table port controls
  always_comb begin
    in_stall  = (st_r != ffba_pkg::S_IDLE);
    out_valid = (st_r == ffba_pkg::S_OUT);
    ra        = i_r;
    rb        = IW'(i_r + 1'b1);
    we        = 1'b0;
    wa        = i_r;
    wd_start  = qa_start_r;
    wd_used   = qa_used_r;
    unique case (st_r)
      ffba_pkg::S_ACHK: begin
        we      = fit;
        wd_used = 1'b1;
      end
      ffba_pkg::S_FCHK: begin
        we      = hit && qa_used_r;
        wd_used = 1'b0;
      end
      ffba_pkg::S_SPLIT: begin
        // move entries up one slot from the top down to i+1
        ra = IW'(j_r - 1'b1);
        wa = j_r;
        if (ph_r) begin
          we = 1'b1;
        end else if (split_done) begin
          we       = 1'b1;
          wd_start = bh_r + HDR_A + size_r;
          wd_used  = 1'b0;
        end
      end
      ffba_pkg::S_SHIFT: begin
        // drop entry by moving the upper ones down one slot
        ra = IW'(j_r + 1'b1);
        wa = j_r;
        we = ph_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      used_r[0]  <= 1'b0;
    end else if (we) begin
      start_r[wa] <= wd_start;
      used_r[wa]  <= wd_used;
    end
  end

  always_ff @(posedge clk) begin
    qa_start_r <= start_r[ra];
    qa_used_r  <= used_r[ra];
    qb_start_r <= start_r[rb];
    qb_used_r  <= used_r[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ffba_pkg::S_IDLE;
      cnt_r  <= CW'(1);
      free_r <= BUF_A - HDR_A;
      i_r    <= '0;
      j_r    <= '0;
      ph_r   <= 1'b0;
      rem_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ffba_pkg::S_IDLE: if (in_valid) begin
          act_r  <= in_action;
          size_r <= AW'(in_req_size);
          hdl_r  <= in_handle;
          i_r    <= '0;
          bh_r   <= '0;
          ph_r   <= 1'b0;
        end
        ffba_pkg::S_ACHK: begin
          if (fit) begin
            stat_r <= ffba_pkg::ST_DONE;
            bh_r   <= qa_start_r;
            if (do_split) begin
              free_r <= free_r - HDR_A - size_r;
              j_r    <= IW'(cnt_r);
            end else begin
              free_r <= free_r - pay;
            end
          end else if (last) begin
            stat_r <= ffba_pkg::ST_NO_FIT;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ffba_pkg::S_SPLIT: begin
          if (!ph_r) begin
            if (split_done) cnt_r <= cnt_r + 1'b1;
            else ph_r <= 1'b1;
          end else begin
            j_r  <= j_r - 1'b1;
            ph_r <= 1'b0;
          end
        end
        ffba_pkg::S_FCHK: begin
          if (hit) begin
            if (qa_used_r) begin
              stat_r <= ffba_pkg::ST_DONE;
              free_r <= free_r + pay + (mrg_hi ? HDR_A : '0) + (mrg_lo ? HDR_A : '0);
              // remove the upper neighbor first, then this entry into the lower one
              j_r    <= mrg_hi ? IW'(i_r + 1'b1) : i_r;
              rm2_r  <= i_r;
              rem_r  <= mrg_hi && mrg_lo;
            end else begin
              stat_r <= ffba_pkg::ST_BAD_HDL;
            end
          end else if (last) begin
            stat_r <= ffba_pkg::ST_BAD_HDL;
          end else begin
            prev_used_r <= qa_used_r;
            i_r <= i_r + 1'b1;
          end
        end
        ffba_pkg::S_SHIFT: begin
          if (!ph_r) begin
            if (shift_end) begin
              cnt_r <= cnt_r - 1'b1;
              if (rem_r) begin
                rem_r <= 1'b0;
                j_r   <= rm2_r;
              end
            end else begin
              ph_r <= 1'b1;
            end
          end else begin
            j_r  <= j_r + 1'b1;
            ph_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/ffba_checker.sv =====
`timescale 1ns / 1ps
module ffba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [12:0] out_free_bytes
);
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open with result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_free_bytes))
    else $error("stalled result changed");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ffba_pkg::ST_BAD_HDL) else $error("bad status");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("no work after accept");
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_free_bytes(out_free_bytes)
);
